>>> rtl/disl_pkg.sv
`timescale 1ns / 1ps
// disl_pkg: shared types, status codes and constants for the sector locator
// used by disl_image_eval, disl_geometry and disk_image_sector_locator_top

package disl_pkg;

   // status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_INVALID     = 3'd1;
   localparam logic [2:0] ST_NOTFOUND    = 3'd2;
   localparam logic [2:0] ST_CORRUPT     = 3'd3;
   localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

   // register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECSIZE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PARAS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILESIZE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITABLE  = 3'd4;

   // image constants
   localparam logic [15:0] IMG_MAGIC   = 16'h0296;
   localparam logic [15:0] SEC_SMALL   = 16'd128;
   localparam logic [15:0] SEC_LARGE   = 16'd256;
   localparam logic [23:0] HDR_BYTES   = 24'd16;
   localparam logic [23:0] BOOT_BYTES  = 24'd384;
   localparam logic [23:0] LARGE_BASE  = 24'd624;

   // geometry constants
   localparam logic [16:0] COUNT_SD    = 17'd720;
   localparam logic [16:0] COUNT_ED    = 17'd1040;
   localparam logic [16:0] COUNT_DS    = 17'd1440;
   localparam logic [16:0] MAX_N18     = 17'd3600;
   localparam logic [16:0] MAX_N26     = 17'd5200;
   localparam logic [4:0]  SPT_18      = 5'd18;
   localparam logic [4:0]  SPT_26      = 5'd26;
   localparam logic [7:0]  CYL_STD     = 8'd40;
   localparam logic [11:0] RECIP18     = 12'd3641;
   localparam logic [11:0] RECIP26     = 12'd2521;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  cylinder;
      logic [7:0]  head_number;
      logic [7:0]  sector_number;
      logic [15:0] transfer_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [13:0] linear_sector;
      logic [23:0] byte_offset;
      logic [8:0]  sector_length;
      logic [17:0] total_sector_count;
      logic [7:0]  cylinder_count;
      logic [1:0]  head_count;
      logic [4:0]  track_sectors;
   } rsp_type;

   typedef struct packed {
      logic        fail;
      logic [2:0]  status;
      logic        mode256;
      logic [16:0] total;
   } img_type;

   typedef struct packed {
      logic        ok;
      logic [7:0]  cyls;
      logic [1:0]  heads;
      logic [4:0]  spt;
   } geo_type;

endpackage

>>> rtl/disk_image_sector_locator_top.sv
`timescale 1ns / 1ps
// disk_image_sector_locator_top: five-stage sector lookup pipeline and registers
// depends on disl_pkg, disl_image_eval, disl_geometry
//
//  channel | direction | handshake           | beat
//  req     | in        | req_valid/req_stall | disl_pkg::req_type
//  rsp     | out       | rsp_valid/rsp_stall | disl_pkg::rsp_type
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// one beat a cycle sustained while rsp_stall is low.
// stages: image check, reciprocal multiply, geometry and argument checks,
// linear sector multiply-add, offset and length checks.
// reset clears the configuration registers and the stage valid bits; csr_ready is always high.
// a stall holds only the stages that are full, bubbles close up behind it.

module disk_image_sector_locator_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  disl_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output disl_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [disl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [disl_pkg::CSR_DATA_W-1:0]  csr_data
);
   import disl_pkg::*;

   // configuration registers
   logic [15:0] magic_ff;
   logic [15:0] secsize_ff;
   logic [31:0] paras_ff;
   logic [23:0] fsize_ff;
   logic        wr_en_ff;

   // stage enables
   logic en1, en2, en3, en4, en5;

   // stage 1
   img_type     s1_img_in;
   img_type     s1_img_ff;
   req_type     s1_req_ff;
   logic        s1_valid_ff;

   // stage 2
   logic [24:0] p18, p26;
   img_type     s2_img_ff;
   req_type     s2_req_ff;
   logic [8:0]  s2_q18_ff, s2_q26_ff;
   logic        s2_valid_ff;

   // stage 3
   geo_type     geo;
   rsp_type     s3_rsp_in, s3_rsp_ff;
   logic        s3_go_in, s3_go_ff;
   logic [5:0]  s3_tpc_in, s3_tpc_ff;
   logic        s3_mode_ff;
   req_type     s3_req_ff;
   logic        s3_valid_ff;

   // stage 4
   logic [13:0] s4_lin_in, s4_lin_ff;
   rsp_type     s4_rsp_ff;
   logic        s4_go_ff;
   logic        s4_mode_ff;
   req_type     s4_req_ff;
   logic        s4_valid_ff;

   // stage 5
   rsp_type     rsp_in, rsp_ff;
   logic        rsp_valid_ff;
   logic [24:0] end_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= '0;
         secsize_ff <= '0;
         paras_ff   <= '0;
         fsize_ff   <= '0;
         wr_en_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAGIC:    magic_ff   <= csr_data[15:0];
            CSR_SECSIZE:  secsize_ff <= csr_data[15:0];
            CSR_PARAS:    paras_ff   <= csr_data[31:0];
            CSR_FILESIZE: fsize_ff   <= csr_data[23:0];
            CSR_WRITABLE: wr_en_ff   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   assign en5 = !rsp_valid_ff || !rsp_stall;
   assign en4 = !s4_valid_ff || en5;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_stall = !en1;

   disl_image_eval u_image (
      .magic       (magic_ff),
      .sector_size (secsize_ff),
      .paragraphs  (paras_ff),
      .image_bytes (fsize_ff),
      .img         (s1_img_in)
   );

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_img_ff <= s1_img_in;
         s1_req_ff <= req_data;
      end
   end

   always_comb begin
      p18 = {12'd0, s1_img_ff.total[12:0]} * {13'd0, RECIP18};
      p26 = {12'd0, s1_img_ff.total[12:0]} * {13'd0, RECIP26};
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_img_ff <= s1_img_ff;
         s2_req_ff <= s1_req_ff;
         s2_q18_ff <= p18[24:16];
         s2_q26_ff <= p26[24:16];
      end
   end

   disl_geometry u_geometry (
      .total   (s2_img_ff.total),
      .mode256 (s2_img_ff.mode256),
      .q18     (s2_q18_ff),
      .q26     (s2_q26_ff),
      .geo     (geo)
   );

   always_comb begin
      s3_rsp_in = '0;
      s3_go_in  = 1'b0;
      s3_rsp_in.total_sector_count = {1'b0, s2_img_ff.total};
      s3_tpc_in = (geo.heads == 2'd2) ? {geo.spt, 1'b0} : {1'b0, geo.spt};
      if (s2_img_ff.fail) begin
         s3_rsp_in.status = s2_img_ff.status;
      end else if (!geo.ok) begin
         s3_rsp_in.status = ST_UNSUPPORTED;
      end else begin
         s3_rsp_in.cylinder_count = geo.cyls;
         s3_rsp_in.head_count     = geo.heads;
         s3_rsp_in.track_sectors  = geo.spt;
         if (s2_req_ff.cmd && !wr_en_ff) begin
            s3_rsp_in.status = ST_UNSUPPORTED;
         end else if (s2_req_ff.sector_number == 8'd0 ||
                      s2_req_ff.sector_number > {3'b000, geo.spt} ||
                      s2_req_ff.head_number >= {6'd0, geo.heads} ||
                      s2_req_ff.cylinder >= geo.cyls) begin
            s3_rsp_in.status = ST_INVALID;
         end else begin
            s3_rsp_in.status = ST_OK;
            s3_go_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_rsp_ff  <= s3_rsp_in;
         s3_go_ff   <= s3_go_in;
         s3_tpc_ff  <= s3_tpc_in;
         s3_mode_ff <= s2_img_ff.mode256;
         s3_req_ff  <= s2_req_ff;
      end
   end

   always_comb begin
      s4_lin_in = 14'd0;
      if (s3_go_ff) begin
         s4_lin_in = ({6'd0, s3_req_ff.cylinder} * {8'd0, s3_tpc_ff})
                   + (s3_req_ff.head_number[0] ? {9'd0, s3_rsp_ff.track_sectors} : 14'd0)
                   + {6'd0, s3_req_ff.sector_number};
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_lin_ff  <= s4_lin_in;
         s4_rsp_ff  <= s3_rsp_ff;
         s4_go_ff   <= s3_go_ff;
         s4_mode_ff <= s3_mode_ff;
         s4_req_ff  <= s3_req_ff;
      end
   end

   always_comb begin
      rsp_in = s4_rsp_ff;
      rsp_in.linear_sector = s4_lin_ff;
      end_pos = '0;
      if (s4_go_ff) begin
         if ({4'd0, s4_lin_ff} > s4_rsp_ff.total_sector_count) begin
            rsp_in.status = ST_NOTFOUND;
         end else begin
            if (s4_mode_ff && s4_lin_ff > 14'd3) begin
               rsp_in.byte_offset   = {2'b00, s4_lin_ff, 8'd0} - LARGE_BASE;
               rsp_in.sector_length = 9'd256;
            end else begin
               rsp_in.byte_offset   = HDR_BYTES + {3'b000, s4_lin_ff - 14'd1, 7'd0};
               rsp_in.sector_length = 9'd128;
            end
            end_pos = {1'b0, rsp_in.byte_offset} + {16'd0, rsp_in.sector_length};
            if (end_pos > {1'b0, fsize_ff}) begin
               rsp_in.status = ST_CORRUPT;
            end else if (!s4_req_ff.cmd &&
                         s4_req_ff.transfer_length < {7'd0, rsp_in.sector_length}) begin
               rsp_in.status = ST_INVALID;
            end else if (s4_req_ff.cmd &&
                         s4_req_ff.transfer_length != {7'd0, rsp_in.sector_length}) begin
               rsp_in.status = ST_INVALID;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff  <= req_valid;
         if (en2) s2_valid_ff  <= s1_valid_ff;
         if (en3) s3_valid_ff  <= s2_valid_ff;
         if (en4) s4_valid_ff  <= s3_valid_ff;
         if (en5) rsp_valid_ff <= s4_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted beat did not enter stage 1");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !en2) |=> (s1_valid_ff && $stable(s1_req_ff)))
      else $error("stalled stage 1 lost its beat");

   a_ok_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_OK) |->
      ((rsp_data.sector_length == 9'd128 || rsp_data.sector_length == 9'd256) &&
       rsp_data.linear_sector != 14'd0 && rsp_data.head_count != 2'd0))
      else $error("ok result without sector length or geometry");
`endif

endmodule

>>> rtl/disl_image_eval.sv
`timescale 1ns / 1ps
// disl_image_eval: header and size checks, data length and sector count
// depends on disl_pkg

module disl_image_eval (
   input  logic [15:0]       magic,
   input  logic [15:0]       sector_size,
   input  logic [31:0]       paragraphs,
   input  logic [23:0]       image_bytes,
   output disl_pkg::img_type img
);
   import disl_pkg::*;

   logic [23:0] fdata;
   logic [23:0] plen;
   logic [23:0] dlen;
   logic        par_big;
   logic [24:0] dsum;

   always_comb begin
      fdata   = image_bytes - HDR_BYTES;
      plen    = {paragraphs[19:0], 4'b0000};
      par_big = (paragraphs[31:20] != 12'd0) || (plen > fdata);
      dlen    = ((paragraphs == 32'd0) || par_big) ? fdata : plen;
      dsum    = {1'b0, dlen} + {1'b0, BOOT_BYTES};
      img     = '0;
      img.status = ST_OK;
      if (image_bytes < HDR_BYTES) begin
         img.fail   = 1'b1;
         img.status = ST_CORRUPT;
      end else if (magic != IMG_MAGIC ||
                   (sector_size != SEC_SMALL && sector_size != SEC_LARGE)) begin
         img.fail   = 1'b1;
         img.status = ST_UNSUPPORTED;
      end else if (sector_size == SEC_SMALL) begin
         img.mode256 = 1'b0;
         if (dlen[6:0] != 7'd0) begin
            img.fail   = 1'b1;
            img.status = ST_CORRUPT;
         end else begin
            img.total = dlen[23:7];
         end
      end else begin
         img.mode256 = 1'b1;
         if (dlen < BOOT_BYTES || dsum[7:0] != 8'd0) begin
            img.fail   = 1'b1;
            img.status = ST_CORRUPT;
         end else begin
            img.total = dsum[24:8];
         end
      end
   end

endmodule

>>> rtl/disl_geometry.sv
`timescale 1ns / 1ps
// disl_geometry: picks cylinders, heads and sectors per track from the count
// depends on disl_pkg; quotients come in precomputed by reciprocal multiply

module disl_geometry (
   input  logic [16:0]       total,
   input  logic              mode256,
   input  logic [8:0]        q18,
   input  logic [8:0]        q26,
   output disl_pkg::geo_type geo
);
   import disl_pkg::*;

   logic [12:0] back18;
   logic [12:0] back26;
   logic        ok18;
   logic        ok26;

   always_comb begin
      back18 = {4'b0000, q18} * 13'd18;
      back26 = {4'b0000, q26} * 13'd26;
      ok18 = (total != 17'd0) && (total <= MAX_N18) && (back18 == total[12:0]);
      ok26 = (total != 17'd0) && (total <= MAX_N26) && (back26 == total[12:0]);
      geo = '0;
      if (total == COUNT_SD) begin
         geo = '{ok: 1'b1, cyls: CYL_STD, heads: 2'd1, spt: SPT_18};
      end else if (!mode256 && total == COUNT_ED) begin
         geo = '{ok: 1'b1, cyls: CYL_STD, heads: 2'd1, spt: SPT_26};
      end else if (total == COUNT_DS) begin
         geo = '{ok: 1'b1, cyls: CYL_STD, heads: 2'd2, spt: SPT_18};
      end else if (ok18) begin
         geo = '{ok: 1'b1, cyls: q18[7:0], heads: 2'd1, spt: SPT_18};
      end else if (!mode256 && ok26) begin
         geo = '{ok: 1'b1, cyls: q26[7:0], heads: 2'd1, spt: SPT_26};
      end
   end

endmodule
